// ----- rtl/core/psd_pkg.sv -----
`timescale 1ns / 1ps
package psd_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF   = 8;

	// result field widths are fixed
	localparam int OUT_BITS = 25;
	localparam int QUO_BITS = 2 * OUT_BITS;
	localparam int OUT_TW   = ((OUT_BITS + 7) / 8) * 8;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_END_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_END_Y   = 3'd3;

	localparam logic [1:0] PART_START    = 2'd0;
	localparam logic [1:0] PART_END      = 2'd1;
	localparam logic [1:0] PART_INTERIOR = 2'd2;

	// side information that rides along the pipeline
	typedef struct packed {
		logic       sat;
		logic [1:0] part;
	} psd_tag_t;

endpackage

// ----- rtl/core/point_segment_distance_top.sv -----
`timescale 1ns / 1ps
// Distance from a stream of query points to one fixed 2D segment. Load the segment endpoints
// through the cfg channel (index 0 start_x, 1 start_y, 2 end_x, 3 end_y, all reset to 0;
// other indexes are ignored) while no beat is in flight. Each slave beat carries one query
// point and yields exactly one master beat: the exact floor(2^FRAC_BITS * distance) as an
// unsigned Q17.8 value in m_tdata (saturated to all ones if it would not fit) and the nearest
// part of the segment in m_tuser (0 start, 1 end, 2 interior). The datapath is a fully
// pipelined chain: six stages of differences, products, sums and a split square, one stage per
// quotient bit of a 50-bit restoring division, and one stage per root bit of a 25-bit
// restoring square root, and a new point is taken every cycle. The whole pipeline advances
// together; it holds only while a finished result waits on m_tready.
module point_segment_distance_top import psd_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// query point in
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_tdata,   // query_x, query_y
	// result out
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [OUT_TW-1:0]               m_tdata,      // distance_q8
	output logic [1:0]                      m_tuser,      // nearest_part
	// register writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [CFG_IDX_W-1:0]            cfg_index,
	input  logic [COORD_WIDTH-1:0]          cfg_data
);
	localparam int CW = COORD_WIDTH;
	localparam int DW = 2 * (CW + 1);

	// segment endpoint registers
	logic [CW-1:0] start_x_q, start_y_q, end_x_q, end_y_q;

	// one enable for every stage: move unless the result register is held
	logic en;
	assign en        = !m_tvalid || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			end_x_q   <= '0;
			end_y_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_START_X: start_x_q <= cfg_data;
				REG_START_Y: start_y_q <= cfg_data;
				REG_END_X:   end_x_q   <= cfg_data;
				REG_END_Y:   end_y_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// division chain: index 0 is the front end output
	logic                v_d   [0:QUO_BITS];
	logic [DW-1:0]       rem_d [0:QUO_BITS];
	logic [QUO_BITS-1:0] nq_d  [0:QUO_BITS];
	logic [DW-1:0]       den_d [0:QUO_BITS];
	psd_tag_t            tag_d [0:QUO_BITS];

	psd_front #(.CW(CW), .FB(FRAC_BITS), .DW(DW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.qx        (s_tdata[CW-1:0]),
		.qy        (s_tdata[2*CW-1:CW]),
		.sx        (start_x_q),
		.sy        (start_y_q),
		.ex        (end_x_q),
		.ey        (end_y_q),
		.out_valid (v_d[0]),
		.out_rem   (rem_d[0]),
		.out_low   (nq_d[0]),
		.out_den   (den_d[0]),
		.out_tag   (tag_d[0])
	);

	genvar gi;
	generate
		for (gi = 0; gi < QUO_BITS; gi++) begin : g_div
			psd_div_stage #(.DW(DW)) u_div (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (en),
				.in_valid  (v_d[gi]),
				.in_rem    (rem_d[gi]),
				.in_nq     (nq_d[gi]),
				.in_den    (den_d[gi]),
				.in_tag    (tag_d[gi]),
				.out_valid (v_d[gi+1]),
				.out_rem   (rem_d[gi+1]),
				.out_nq    (nq_d[gi+1]),
				.out_den   (den_d[gi+1]),
				.out_tag   (tag_d[gi+1])
			);
		end
	endgenerate

	// square root chain on the quotient
	logic                v_r    [0:OUT_BITS];
	logic [QUO_BITS-1:0] n_r    [0:OUT_BITS];
	logic [OUT_BITS+1:0] rem_r  [0:OUT_BITS];
	logic [OUT_BITS-1:0] root_r [0:OUT_BITS];
	psd_tag_t            tag_r  [0:OUT_BITS];

	assign v_r[0]    = v_d[QUO_BITS];
	assign n_r[0]    = nq_d[QUO_BITS];
	assign rem_r[0]  = '0;
	assign root_r[0] = '0;
	assign tag_r[0]  = tag_d[QUO_BITS];

	generate
		for (gi = 0; gi < OUT_BITS; gi++) begin : g_sqrt
			psd_sqrt_stage u_sqrt (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (en),
				.in_valid  (v_r[gi]),
				.in_n      (n_r[gi]),
				.in_rem    (rem_r[gi]),
				.in_root   (root_r[gi]),
				.in_tag    (tag_r[gi]),
				.out_valid (v_r[gi+1]),
				.out_n     (n_r[gi+1]),
				.out_rem   (rem_r[gi+1]),
				.out_root  (root_r[gi+1]),
				.out_tag   (tag_r[gi+1])
			);
		end
	endgenerate

	// the last root stage is the output register
	logic [OUT_BITS-1:0] distance;
	assign distance = tag_r[OUT_BITS].sat ? '1 : root_r[OUT_BITS];
	assign m_tvalid = v_r[OUT_BITS];
	assign m_tdata  = OUT_TW'(distance);
	assign m_tuser  = tag_r[OUT_BITS].part;

	// nearest part code is one of the three meaningful values
	a_part_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == PART_START || m_tuser == PART_END || m_tuser == PART_INTERIOR))
		else $error("illegal nearest part code");

	// the input side only stalls behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without a held result");

	// a held result keeps its root and tag until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(root_r[OUT_BITS])
			&& $stable(tag_r[OUT_BITS])))
		else $error("held result changed");

endmodule

// ----- rtl/core/psd_front.sv -----
`timescale 1ns / 1ps
module psd_front import psd_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF,
	parameter int FB = FRAC_BITS_DEF,
	parameter int DW = 2 * (CW + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [CW-1:0]        qx,
	input  logic [CW-1:0]        qy,
	input  logic [CW-1:0]        sx,
	input  logic [CW-1:0]        sy,
	input  logic [CW-1:0]        ex,
	input  logic [CW-1:0]        ey,
	output logic                 out_valid,
	output logic [DW-1:0]        out_rem,
	output logic [QUO_BITS-1:0]  out_low,
	output logic [DW-1:0]        out_den,
	output psd_tag_t             out_tag
);
	localparam int D   = CW + 1;
	localparam int PW  = 2 * D;
	localparam int AW  = PW + 1;
	localparam int H   = (AW + 1) / 2;
	localparam int HH  = AW - H;
	localparam int SQW = 2 * AW;
	localparam int NW  = SQW + 2 * FB;
	localparam int EW  = (NW > QUO_BITS) ? NW : QUO_BITS + 1;

	logic [5:0] v_q;

	// stage 1: differences
	logic signed [D-1:0] lx_s1, ly_s1, rx_s1, ry_s1, dx_s1, dy_s1;
	// stage 2: products
	logic signed [PW-1:0] rxlx_s2, ryly_s2, lxlx_s2, lyly_s2, lxry_s2, lyrx_s2;
	logic signed [PW-1:0] rxrx_s2, ryry_s2, dxdx_s2, dydy_s2;
	// stage 3: sums
	logic signed [AW-1:0] along_s3, len2_s3, cr_s3, ss_s3, se_s3;
	// stage 4: region and partial products of the square
	logic [2*HH-1:0]   hh_s4;
	logic [HH+H-1:0]   hl_s4;
	logic [2*H-1:0]    ll_s4;
	logic [AW-1:0]     mag_s4;
	logic [DW-1:0]     den_s4, den_s5;
	logic [1:0]        part_s4, part_s5;
	// stage 5: scaled numerator
	logic [EW-1:0]     num_s5;

	logic [1:0]        part_c;
	logic [AW-1:0]     mag_c;
	logic [AW-1:0]     abs_cr;
	logic [SQW-1:0]    sq_c;
	logic [SQW-1:0]    base_c;
	logic [EW-1:0]     hi_c;
	logic              sat_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[4:0], in_valid};
		end
	end

	always_comb begin
		abs_cr = cr_s3[AW-1] ? AW'(-cr_s3) : AW'(cr_s3);
		if (along_s3[AW-1] || along_s3 == '0) begin
			part_c = PART_START;
			mag_c  = AW'(ss_s3);
		end else if (len2_s3 <= along_s3) begin
			part_c = PART_END;
			mag_c  = AW'(se_s3);
		end else begin
			part_c = PART_INTERIOR;
			mag_c  = abs_cr;
		end
		sq_c = (SQW'(hh_s4) << (2 * H)) + (SQW'(hl_s4) << (H + 1)) + SQW'(ll_s4);
		base_c = (part_s4 == PART_INTERIOR) ? sq_c : SQW'(mag_s4);
		hi_c  = num_s5 >> QUO_BITS;
		sat_c = hi_c >= EW'(den_s5);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lx_s1 <= $signed({ex[CW-1], ex}) - $signed({sx[CW-1], sx});
			ly_s1 <= $signed({ey[CW-1], ey}) - $signed({sy[CW-1], sy});
			rx_s1 <= $signed({qx[CW-1], qx}) - $signed({sx[CW-1], sx});
			ry_s1 <= $signed({qy[CW-1], qy}) - $signed({sy[CW-1], sy});
			dx_s1 <= $signed({qx[CW-1], qx}) - $signed({ex[CW-1], ex});
			dy_s1 <= $signed({qy[CW-1], qy}) - $signed({ey[CW-1], ey});

			rxlx_s2 <= rx_s1 * lx_s1;
			ryly_s2 <= ry_s1 * ly_s1;
			lxlx_s2 <= lx_s1 * lx_s1;
			lyly_s2 <= ly_s1 * ly_s1;
			lxry_s2 <= lx_s1 * ry_s1;
			lyrx_s2 <= ly_s1 * rx_s1;
			rxrx_s2 <= rx_s1 * rx_s1;
			ryry_s2 <= ry_s1 * ry_s1;
			dxdx_s2 <= dx_s1 * dx_s1;
			dydy_s2 <= dy_s1 * dy_s1;

			along_s3 <= AW'(rxlx_s2) + AW'(ryly_s2);
			len2_s3  <= AW'(lxlx_s2) + AW'(lyly_s2);
			cr_s3    <= AW'(lxry_s2) - AW'(lyrx_s2);
			ss_s3    <= AW'(rxrx_s2) + AW'(ryry_s2);
			se_s3    <= AW'(dxdx_s2) + AW'(dydy_s2);

			hh_s4   <= (2*HH)'(mag_c[AW-1:H]) * (2*HH)'(mag_c[AW-1:H]);
			hl_s4   <= (HH+H)'(mag_c[AW-1:H]) * (HH+H)'(mag_c[H-1:0]);
			ll_s4   <= (2*H)'(mag_c[H-1:0]) * (2*H)'(mag_c[H-1:0]);
			mag_s4  <= mag_c;
			part_s4 <= part_c;
			den_s4  <= (part_c == PART_INTERIOR) ? len2_s3[DW-1:0] : DW'(1);

			num_s5  <= EW'(base_c) << (2 * FB);
			den_s5  <= den_s4;
			part_s5 <= part_s4;

			out_rem      <= sat_c ? '0 : hi_c[DW-1:0];
			out_low      <= num_s5[QUO_BITS-1:0];
			out_den      <= den_s5;
			out_tag.sat  <= sat_c;
			out_tag.part <= part_s5;
		end
	end

	assign out_valid = v_q[5];

endmodule

// ----- rtl/core/psd_div_stage.sv -----
`timescale 1ns / 1ps
module psd_div_stage import psd_pkg::*; #(
	parameter int DW = 2 * (COORD_WIDTH_DEF + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [DW-1:0]       in_rem,
	input  logic [QUO_BITS-1:0] in_nq,
	input  logic [DW-1:0]       in_den,
	input  psd_tag_t            in_tag,
	output logic                out_valid,
	output logic [DW-1:0]       out_rem,
	output logic [QUO_BITS-1:0] out_nq,
	output logic [DW-1:0]       out_den,
	output psd_tag_t            out_tag
);
	logic [DW:0] t;
	logic        ge;

	// one quotient bit: shift in the next numerator bit, trial subtract
	always_comb begin
		t  = {in_rem, in_nq[QUO_BITS-1]};
		ge = t >= {1'b0, in_den};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_rem <= ge ? DW'(t - {1'b0, in_den}) : DW'(t);
			out_nq  <= {in_nq[QUO_BITS-2:0], ge};
			out_den <= in_den;
			out_tag <= in_tag;
		end
	end

endmodule

// ----- rtl/core/psd_sqrt_stage.sv -----
`timescale 1ns / 1ps
module psd_sqrt_stage import psd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [QUO_BITS-1:0] in_n,
	input  logic [OUT_BITS+1:0] in_rem,
	input  logic [OUT_BITS-1:0] in_root,
	input  psd_tag_t            in_tag,
	output logic                out_valid,
	output logic [QUO_BITS-1:0] out_n,
	output logic [OUT_BITS+1:0] out_rem,
	output logic [OUT_BITS-1:0] out_root,
	output psd_tag_t            out_tag
);
	localparam int RW = OUT_BITS + 2;

	logic [RW+1:0] t;
	logic [RW+1:0] trial;
	logic          ge;

	// one root bit: bring down two radicand bits, try (root << 2) | 1
	always_comb begin
		t     = {in_rem, in_n[QUO_BITS-1:QUO_BITS-2]};
		trial = (RW+2)'({in_root, 2'b01});
		ge    = t >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_rem  <= ge ? RW'(t - trial) : RW'(t);
			out_root <= {in_root[OUT_BITS-2:0], ge};
			out_n    <= in_n << 2;
			out_tag  <= in_tag;
		end
	end

endmodule
